// ===== sv/hvt_pkg.sv =====
// shared types, widths and reset values for the vertex transform unit
`timescale 1ns / 1ps
`default_nettype none
package hvt_pkg;
    localparam int COORD_W_DEF = 32;              // default significant coordinate bits
    localparam int FIELD_W     = 32;              // width of every coordinate field
    localparam int COEF_W      = 32;              // q16.16 coefficient
    localparam int PROD_W      = 2 * COEF_W;      // exact q32.32 product
    localparam int SUM_W       = PROD_W + 2;      // three products plus translation
    localparam int FRAC        = 16;              // fraction bits
    localparam int V_W         = SUM_W - FRAC;    // row result after floor
    localparam int Q_W         = 31;              // quotient magnitude bits
    localparam int SAT_SHIFT   = Q_W - FRAC;      // integer part limit is 2^15
    localparam int N_CFG       = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = $clog2(N_CFG);

    localparam logic [CFG_W-1:0] CFG_RESET [N_CFG] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    typedef logic [N_CFG-1:0][CFG_W-1:0] t_cfg;

    // one numerator lane of the divider
    typedef struct packed {
        logic [V_W-1:0]       rem;
        logic [Q_W-1:0]       q;
        logic [SAT_SHIFT-1:0] nlo;   // numerator bits still to shift in
        logic                 neg;
        logic                 sat;
        logic                 npos;
        logic                 nneg;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]    lane;
        logic [V_W-1:0] ad;          // divisor magnitude
        logic           wz;
    } t_div;

    // coefficient m[row][col] from the packed column registers
    function automatic logic signed [COEF_W-1:0] coef(t_cfg cfg, logic [1:0] row,
                                                      logic [1:0] col);
        logic [CFG_W-1:0] r;
        r = cfg[{col, row[1]}];
        return row[0] ? r[CFG_W-1:COEF_W] : r[COEF_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/hvt_matrix.sv =====
// matrix multiply, row sums and divider setup (three stages)
`timescale 1ns / 1ps
`default_nettype none
module hvt_matrix #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_W_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [hvt_pkg::FIELD_W-1:0] i_x,
    input  wire logic [hvt_pkg::FIELD_W-1:0] i_y,
    input  wire logic [hvt_pkg::FIELD_W-1:0] i_z,
    input  wire hvt_pkg::t_cfg               i_cfg,
    output logic                             o_valid,
    output hvt_pkg::t_div                    o_div
);
    localparam int SH = hvt_pkg::FIELD_W - COORD_WIDTH;

    logic signed [hvt_pkg::FIELD_W-1:0] w_p [3];
    logic signed [hvt_pkg::PROD_W-1:0]  r_prod [4][3];
    logic signed [hvt_pkg::COEF_W-1:0]  r_trans [4];
    logic signed [hvt_pkg::SUM_W-1:0]   n_sum [4];
    logic signed [hvt_pkg::V_W-1:0]     r_v [4];
    logic [hvt_pkg::V_W-1:0]            n_an [3];
    logic [hvt_pkg::V_W-1:0]            n_ad;
    hvt_pkg::t_div                      n_div;
    hvt_pkg::t_div                      r_div;
    logic [2:0]                         r_vld;

    // keep the low coordinate bits, sign extended
    assign w_p[0] = $signed(i_x << SH) >>> SH;
    assign w_p[1] = $signed(i_y << SH) >>> SH;
    assign w_p[2] = $signed(i_z << SH) >>> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= hvt_pkg::coef(i_cfg, 2'(r), 2'(c)) * w_p[c];
                end
                r_trans[r] <= hvt_pkg::coef(i_cfg, 2'(r), 2'd3);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_sum[r] = hvt_pkg::SUM_W'(r_prod[r][0]) + hvt_pkg::SUM_W'(r_prod[r][1])
                     + hvt_pkg::SUM_W'(r_prod[r][2])
                     + (hvt_pkg::SUM_W'(r_trans[r]) <<< hvt_pkg::FRAC);
        end
    end

    // floor to q16.16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_v[r] <= n_sum[r][hvt_pkg::SUM_W-1:hvt_pkg::FRAC];
            end
        end
    end

    always_comb begin
        n_ad     = r_v[3][hvt_pkg::V_W-1] ? hvt_pkg::V_W'(-r_v[3]) : r_v[3];
        n_div.ad = n_ad;
        n_div.wz = (r_v[3] == '0);
        for (int l = 0; l < 3; l++) begin
            n_an[l] = r_v[l][hvt_pkg::V_W-1] ? hvt_pkg::V_W'(-r_v[l]) : r_v[l];
            n_div.lane[l].rem  = n_an[l] >> hvt_pkg::SAT_SHIFT;
            n_div.lane[l].sat  = (n_an[l] >> hvt_pkg::SAT_SHIFT) >= n_ad;
            n_div.lane[l].q    = '0;
            n_div.lane[l].nlo  = n_an[l][hvt_pkg::SAT_SHIFT-1:0];
            n_div.lane[l].neg  = r_v[l][hvt_pkg::V_W-1] ^ r_v[3][hvt_pkg::V_W-1];
            n_div.lane[l].nneg = r_v[l][hvt_pkg::V_W-1];
            n_div.lane[l].npos = !r_v[l][hvt_pkg::V_W-1] && (r_v[l] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_div   = r_div;
endmodule
`default_nettype wire

// ===== sv/hvt_div_step.sv =====
// one restoring division step for three numerators sharing a divisor
`timescale 1ns / 1ps
`default_nettype none
module hvt_div_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire hvt_pkg::t_div i_div,
    output logic               o_valid,
    output hvt_pkg::t_div      o_div
);
    logic [hvt_pkg::V_W:0] n_rem2 [3];
    hvt_pkg::t_div         n_div;
    hvt_pkg::t_div         r_div;
    logic                  r_valid;

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < 3; l++) begin
            n_rem2[l] = {i_div.lane[l].rem, i_div.lane[l].nlo[hvt_pkg::SAT_SHIFT-1]};
            n_div.lane[l].nlo = {i_div.lane[l].nlo[hvt_pkg::SAT_SHIFT-2:0], 1'b0};
            if (n_rem2[l] >= {1'b0, i_div.ad}) begin
                n_div.lane[l].rem = hvt_pkg::V_W'(n_rem2[l] - {1'b0, i_div.ad});
                n_div.lane[l].q   = {i_div.lane[l].q[hvt_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_div.lane[l].rem = n_rem2[l][hvt_pkg::V_W-1:0];
                n_div.lane[l].q   = {i_div.lane[l].q[hvt_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule
`default_nettype wire

// ===== sv/homogeneous_vertex_transform_unit.sv =====
// top level: 4x4 vertex transform with perspective divide and saturation
// pipeline: 3 matrix stages, 31 divider stages at one quotient bit each,
//   1 output register
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: synchronous active low, clears all valid bits and loads the identity matrix
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_vertex_transform_unit #(
    parameter int COORD_WIDTH = hvt_pkg::COORD_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [3*hvt_pkg::FIELD_W-1:0] s_axis_tdata,  // pos_x, pos_y, pos_z
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [3*hvt_pkg::FIELD_W-1:0]      m_axis_tdata,  // proj_x, proj_y, proj_z
    output logic                               m_axis_tuser,  // w_zero
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [hvt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hvt_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int F = hvt_pkg::FIELD_W;
    // saturation limits of the signed coordinate range, as 32-bit patterns
    localparam logic [F-1:0] LIM_NEG  = F'(64'd1 << (COORD_WIDTH - 1));
    localparam logic [F-1:0] LIM_POS  = LIM_NEG - F'(1);
    localparam logic [F-1:0] MIN_BITS = ~LIM_NEG + F'(1);

    hvt_pkg::t_cfg       r_cfg;
    logic                w_en;
    logic                w_vld [hvt_pkg::Q_W+1];
    hvt_pkg::t_div       w_div [hvt_pkg::Q_W+1];
    logic                r_out_valid;
    logic [3*F-1:0]      r_out_data;
    logic                r_out_wz;
    logic [3*F-1:0]      n_out_data;
    logic [F-1:0]        n_qz [3];

    // config registers, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hvt_pkg::N_CFG; k++) begin
                r_cfg[k] <= hvt_pkg::CFG_RESET[k];
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // global advance: move whenever the output slot is free or being emptied
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    hvt_matrix #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(s_axis_tvalid),
        .i_x    (s_axis_tdata[F-1:0]),
        .i_y    (s_axis_tdata[2*F-1:F]),
        .i_z    (s_axis_tdata[3*F-1:2*F]),
        .i_cfg  (r_cfg),
        .o_valid(w_vld[0]),
        .o_div  (w_div[0])
    );

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < hvt_pkg::Q_W; k++) begin : g_div
        hvt_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_vld[k]),
            .i_div  (w_div[k]),
            .o_valid(w_vld[k+1]),
            .o_div  (w_div[k+1])
        );
    end

    // sign, saturation and the w == 0 case
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_qz[l] = {1'b0, w_div[hvt_pkg::Q_W].lane[l].q};
            if (w_div[hvt_pkg::Q_W].wz) begin
                n_out_data[l*F +: F] = w_div[hvt_pkg::Q_W].lane[l].npos ? LIM_POS :
                                       w_div[hvt_pkg::Q_W].lane[l].nneg ? MIN_BITS : '0;
            end else if (w_div[hvt_pkg::Q_W].lane[l].sat) begin
                n_out_data[l*F +: F] = w_div[hvt_pkg::Q_W].lane[l].neg ? MIN_BITS : LIM_POS;
            end else if (w_div[hvt_pkg::Q_W].lane[l].neg) begin
                n_out_data[l*F +: F] = (n_qz[l] > LIM_NEG) ? MIN_BITS : F'(-n_qz[l]);
            end else begin
                n_out_data[l*F +: F] = (n_qz[l] > LIM_POS) ? LIM_POS : n_qz[l];
            end
        end
    end

    // output register parts the pipeline from the consumer
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_wz   <= w_div[hvt_pkg::Q_W].wz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vld[hvt_pkg::Q_W];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_wz;

    // input side follows the output slot
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output slot");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // w == 0 only gives limits or zero
    a_wz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ((m_axis_tdata[F-1:0] == LIM_POS) || (m_axis_tdata[F-1:0] == MIN_BITS)
             || (m_axis_tdata[F-1:0] == '0))
            && ((m_axis_tdata[2*F-1:F] == LIM_POS) || (m_axis_tdata[2*F-1:F] == MIN_BITS)
             || (m_axis_tdata[2*F-1:F] == '0))
            && ((m_axis_tdata[3*F-1:2*F] == LIM_POS)
             || (m_axis_tdata[3*F-1:2*F] == MIN_BITS)
             || (m_axis_tdata[3*F-1:2*F] == '0)))
        else $error("w zero result not saturated");
endmodule
`default_nettype wire
